// ===== sv/pfc_pkg.sv =====
// ----------------------------------------------------------------------------
// Pixel format converter package
// Format codes, transaction payload types, register map and the decode and
// encode helpers shared by the converter.
// ----------------------------------------------------------------------------
package pfc_pkg;

   // Default palette depth
   localparam int unsigned PALETTE_ENTRIES_DEF = 256;

   // Configuration port
   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 32;

   // Register indexes (byte address is 4 * index)
   localparam logic [1:0] REG_SOURCE_FORMAT   = 2'd0;
   localparam logic [1:0] REG_DEST_FORMAT     = 2'd1;
   localparam logic [1:0] REG_PALETTE_ENABLED = 2'd2;

   // Action codes
   localparam logic ACT_CONVERT   = 1'b0;
   localparam logic ACT_PAL_WRITE = 1'b1;

   // Status codes
   localparam logic ST_CONVERTED   = 1'b0;
   localparam logic ST_UNSUPPORTED = 1'b1;

   localparam logic [31:0] OPAQUE_BLACK = 32'hFF00_0000;

   typedef enum logic [2:0] {
      FMT_RGB888   = 3'd0,
      FMT_ARGB8888 = 3'd1,
      FMT_XRGB8888 = 3'd2,
      FMT_RGB565   = 3'd3,
      FMT_XRGB1555 = 3'd4,
      FMT_ARGB1555 = 3'd5,
      FMT_ARGB4444 = 3'd6,
      FMT_PAL8     = 3'd7
   } fmt_type;

   typedef struct packed {
      logic        action;
      logic [31:0] source_pixel;
      logic [7:0]  palette_index;
      logic [23:0] palette_color;
   } req_type;

   typedef struct packed {
      logic [31:0] dest_pixel;
      logic        status;
   } rsp_type;

   // v * 255 / 31 = 8v + floor(7v / 31); the floor is taken as (n * 265) >> 13,
   // exact for n up to 217
   function automatic logic [7:0] widen5(input logic [4:0] v);
      logic [7:0]  n;
      logic [16:0] p;
      begin
         n = 8'(v) * 8'd7;
         p = 17'(n) * 17'd265;
         widen5 = {v, 3'b000} + {5'b00000, p[15:13]};
      end
   endfunction

   // v * 255 / 63 = 4v + floor(v / 21); the floor is taken as (v * 49) >> 10
   function automatic logic [7:0] widen6(input logic [5:0] v);
      logic [11:0] p;
      begin
         p = 12'(v) * 12'd49;
         widen6 = {v, 2'b00} + {6'b000000, p[11:10]};
      end
   endfunction

   function automatic logic [31:0] format_mask(input fmt_type fmt);
      case (fmt)
         FMT_RGB888:                 format_mask = 32'h00FF_FFFF;
         FMT_ARGB8888, FMT_XRGB8888: format_mask = 32'hFFFF_FFFF;
         FMT_PAL8:                   format_mask = 32'h0000_00FF;
         default:                    format_mask = 32'h0000_FFFF;
      endcase
   endfunction

   // pal_argb: palette colour already resolved to ARGB8888
   function automatic logic [31:0] decode_argb(input logic [31:0] px, input fmt_type fmt,
                                               input logic [31:0] pal_argb);
      logic [15:0] h;
      logic [7:0]  a;
      begin
         h = px[15:0];
         a = (fmt == FMT_ARGB1555 && !h[15]) ? 8'h00 : 8'hFF;
         case (fmt)
            FMT_PAL8:     decode_argb = pal_argb;
            FMT_RGB888:   decode_argb = {8'hFF, px[23:0]};
            FMT_ARGB8888: decode_argb = px;
            FMT_XRGB8888: decode_argb = px | OPAQUE_BLACK;
            FMT_RGB565:   decode_argb = {8'hFF, widen5(h[15:11]), widen6(h[10:5]),
                                         widen5(h[4:0])};
            FMT_XRGB1555, FMT_ARGB1555: begin
               decode_argb = {a, widen5(h[14:10]), widen5(h[9:5]), widen5(h[4:0])};
            end
            default: begin
               decode_argb = {h[15:12], h[15:12], h[11:8], h[11:8],
                              h[7:4], h[7:4], h[3:0], h[3:0]};
            end
         endcase
      end
   endfunction

   function automatic logic [31:0] encode_argb(input logic [31:0] c, input fmt_type fmt);
      logic [7:0] a, r, g, b;
      begin
         a = c[31:24];
         r = c[23:16];
         g = c[15:8];
         b = c[7:0];
         case (fmt)
            FMT_RGB888:   encode_argb = {8'h00, r, g, b};
            FMT_ARGB8888: encode_argb = c;
            FMT_XRGB8888: encode_argb = c | OPAQUE_BLACK;
            FMT_RGB565:   encode_argb = {16'h0000, r[7:3], g[7:2], b[7:3]};
            FMT_XRGB1555: encode_argb = {16'h0000, 1'b1, r[7:3], g[7:3], b[7:3]};
            FMT_ARGB1555: encode_argb = {16'h0000, a[7], r[7:3], g[7:3], b[7:3]};
            FMT_ARGB4444: encode_argb = {16'h0000, a[7:4], r[7:4], g[7:4], b[7:4]};
            default:      encode_argb = 32'h0000_0000;
         endcase
      end
   endfunction

endpackage

// ===== sv/pixel_format_converter.sv =====
// ----------------------------------------------------------------------------
// Pixel format converter
// Converts a stream of pixels between packed RGB formats, with a palette store.
// ----------------------------------------------------------------------------
// Usage notes:
//  - req channel: one transaction per pixel (action convert) or per palette
//    entry write (action palette write). A palette write gives no response.
//  - rsp channel: one transaction per convert, in order: dest_pixel and status.
//  - Throughput: one request per cycle while rsp_stall is low, convert and palette
//    write mixed freely. The palette store is a single synchronous RAM; one request
//    per cycle uses either its write port or its read port, never both.
//  - Path: an accepted convert goes through the RAM read stage (s1), then
//    the decode/encode stage into the output register that drives rsp_valid.
//  - Stalls: with rsp_stall high the output register holds; the stage before
//    it fills, then req_stall rises in the same cycle. Releasing rsp_stall
//    frees the pipe at once, so there are no bubbles.
//  - Reset: source and dest format return to argb8888, palette disabled,
//    pipeline empties. The palette reads as zero through per-entry valid bits
//    cleared at reset; no clearing pass is needed.
//  - Configure over APB only while the converter is idle.
// ----------------------------------------------------------------------------
module pixel_format_converter #(
   parameter int unsigned PALETTE_ENTRIES = pfc_pkg::PALETTE_ENTRIES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  pfc_pkg::req_type                 req_data,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output pfc_pkg::rsp_type                 rsp_data,
   // APB-style register port
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [pfc_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [pfc_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [pfc_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);

   localparam int unsigned IDX_W = $clog2(PALETTE_ENTRIES);

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   pfc_pkg::fmt_type source_format_ff, source_format_in;
   pfc_pkg::fmt_type dest_format_ff,   dest_format_in;
   logic             palette_enabled_ff, palette_enabled_in;

   logic        csr_wr;
   logic [1:0]  csr_idx;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite && pready;
   assign csr_idx = paddr[3:2];

   always_comb begin
      source_format_in   = source_format_ff;
      dest_format_in     = dest_format_ff;
      palette_enabled_in = palette_enabled_ff;
      if (csr_wr) begin
         case (csr_idx)
            pfc_pkg::REG_SOURCE_FORMAT:   source_format_in = pfc_pkg::fmt_type'(pwdata[2:0]);
            pfc_pkg::REG_DEST_FORMAT:     dest_format_in   = pfc_pkg::fmt_type'(pwdata[2:0]);
            pfc_pkg::REG_PALETTE_ENABLED: palette_enabled_in = pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         pfc_pkg::REG_SOURCE_FORMAT:   prdata = {29'd0, source_format_ff};
         pfc_pkg::REG_DEST_FORMAT:     prdata = {29'd0, dest_format_ff};
         pfc_pkg::REG_PALETTE_ENABLED: prdata = {31'd0, palette_enabled_ff};
         default:                      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         source_format_ff   <= pfc_pkg::FMT_ARGB8888;
         dest_format_ff     <= pfc_pkg::FMT_ARGB8888;
         palette_enabled_ff <= 1'b0;
      end else begin
         source_format_ff   <= source_format_in;
         dest_format_ff     <= dest_format_in;
         palette_enabled_ff <= palette_enabled_in;
      end
   end

   // ---------------------------------------------------------------------
   // Pipeline control: read stage (s1) then output register
   // ---------------------------------------------------------------------
   logic s1_vld_ff, s1_vld_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free, s1_free, s1_move;
   logic req_accept, conv_accept, pal_wr;
   logic idx_in_range;

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign s1_move     = s1_vld_ff && out_free;
   assign s1_free     = !s1_vld_ff || out_free;
   assign req_stall   = !s1_free;
   assign req_accept  = req_valid && !req_stall;
   assign conv_accept = req_accept && (req_data.action == pfc_pkg::ACT_CONVERT);

   // Palette writes outside the store are dropped
   assign idx_in_range = {1'b0, req_data.palette_index} < 9'(PALETTE_ENTRIES);
   assign pal_wr = req_accept && (req_data.action == pfc_pkg::ACT_PAL_WRITE) && idx_in_range;

   always_comb begin
      s1_vld_in = s1_vld_ff;
      if (s1_free) begin
         s1_vld_in = conv_accept;
      end
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = s1_move;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_vld_ff    <= s1_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // ---------------------------------------------------------------------
   // Palette store: one write or one read per cycle, registered read.
   // Writes and reads come from separate transactions in separate cycles, and
   // a read issued the cycle after a write sees it, so no bypass is needed.
   // ---------------------------------------------------------------------
   logic [23:0]                pal_mem [PALETTE_ENTRIES];
   logic [PALETTE_ENTRIES-1:0] pal_vld_ff;
   logic [IDX_W-1:0]           wr_idx, rd_idx;
   logic [23:0]                pal_rd_ff;
   logic                       pal_rd_vld_ff;
   logic                       pix_in_range;

   assign wr_idx       = req_data.palette_index[IDX_W-1:0];
   assign rd_idx       = req_data.source_pixel[IDX_W-1:0];
   assign pix_in_range = {1'b0, req_data.source_pixel[7:0]} < 9'(PALETTE_ENTRIES);

   always_ff @(posedge clock) begin
      if (pal_wr) begin
         pal_mem[wr_idx] <= req_data.palette_color;
      end
   end

   always_ff @(posedge clock) begin
      if (conv_accept) begin
         pal_rd_ff <= pal_mem[rd_idx];
      end
   end

   // Entry valid bits stand in for clearing the store at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         pal_vld_ff <= '0;
      end else if (pal_wr) begin
         pal_vld_ff[wr_idx] <= 1'b1;
      end
   end

   // s1 payload
   logic [31:0] s1_pixel_ff;
   logic        s1_in_range_ff;

   always_ff @(posedge clock) begin
      if (conv_accept) begin
         s1_pixel_ff    <= req_data.source_pixel;
         s1_in_range_ff <= pix_in_range;
         pal_rd_vld_ff  <= pal_vld_ff[rd_idx];
      end
   end

   // ---------------------------------------------------------------------
   // Convert stage: copy, reject PAL8 or decode to ARGB8888, encode to destination
   // ---------------------------------------------------------------------
   logic [31:0]      pal_argb, argb;
   pfc_pkg::rsp_type rsp_in;
   pfc_pkg::rsp_type rsp_ff;

   always_comb begin
      if (!palette_enabled_ff || !s1_in_range_ff) begin
         pal_argb = pfc_pkg::OPAQUE_BLACK;
      end else begin
         pal_argb = {8'hFF, (pal_rd_vld_ff ? pal_rd_ff : 24'h000000)};
      end
      argb = pfc_pkg::decode_argb(s1_pixel_ff, source_format_ff, pal_argb);

      if (source_format_ff == dest_format_ff) begin
         // same format: raw pass-through
         rsp_in.dest_pixel = s1_pixel_ff & pfc_pkg::format_mask(source_format_ff);
         rsp_in.status     = pfc_pkg::ST_CONVERTED;
      end else if (dest_format_ff == pfc_pkg::FMT_PAL8) begin
         // no quantiser to a palette
         rsp_in.dest_pixel = 32'h0000_0000;
         rsp_in.status     = pfc_pkg::ST_UNSUPPORTED;
      end else begin
         rsp_in.dest_pixel = pfc_pkg::encode_argb(argb, dest_format_ff) &
                             pfc_pkg::format_mask(dest_format_ff);
         rsp_in.status     = pfc_pkg::ST_CONVERTED;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_vld_ff && rsp_valid_ff && rsp_stall))
      else $error("request stalled with room in the pipeline");

   a_rsp_from_s1: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_vld_ff))
      else $error("response appeared without a transaction in the read stage");

   a_convert_enters_s1: assert property (@(posedge clock) disable iff (reset)
      conv_accept |=> s1_vld_ff)
      else $error("accepted convert transaction lost");

   a_write_not_s1: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_data.action == pfc_pkg::ACT_PAL_WRITE && !s1_vld_ff) |=> !s1_vld_ff)
      else $error("palette write produced a response");

endmodule
